// ===== rtl/ffc_pkg.sv =====
// shared types, constants and the byte-wide crc-32 update for the frame checker
// no dependencies; used by every other file of the block but ffc_if
package ffc_pkg;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_LENGTH  = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_NODE    = 3'd4,
    ST_LINKS   = 3'd5,
    ST_CRC     = 3'd6
  } status_t;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [7:0]  VERSION_RESET = 8'd1;

  localparam logic [7:0] MAGIC [4] = '{8'h45, 8'h47, 8'h43, 8'h46};

  // header byte positions
  localparam logic [7:0] POS_VERSION = 8'd4;
  localparam logic [7:0] POS_NODE    = 8'd5;
  localparam logic [7:0] POS_FLAGS   = 8'd6;
  localparam logic [7:0] POS_LINKS   = 8'd7;
  localparam logic [7:0] POS_SEQ     = 8'd8;
  localparam logic [7:0] POS_EPOCH   = 8'd12;
  localparam logic [7:0] POS_BODY    = 8'd16;
  localparam logic [7:0] POS_MAX     = 8'd255;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stage_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic        frame_done;
    logic [2:0]  status;
    logic [7:0]  node_id;
    logic [7:0]  header_flags;
    logic [7:0]  links_used;
    logic [31:0] sequence_res;
    logic [31:0] epoch_stamp;
  } res_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

// ===== rtl/ffc_if.sv =====
// valid/ready channel interfaces for the frame checker: frame words, results, config
// no dependencies
interface ffc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;
  modport source (output valid, in_byte, last_byte, input ready);
  modport sink (input valid, in_byte, last_byte, output ready);
endinterface

interface ffc_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [7:0]  byte_index;
  logic        frame_done;
  logic [2:0]  status;
  logic [7:0]  node_id;
  logic [7:0]  header_flags;
  logic [7:0]  links_used;
  logic [31:0] sequence_res;
  logic [31:0] epoch_stamp;
  modport source (output valid, data_byte, byte_index, frame_done, status, node_id,
                  header_flags, links_used, sequence_res, epoch_stamp, input ready);
  modport sink (input valid, data_byte, byte_index, frame_done, status, node_id,
                header_flags, links_used, sequence_res, epoch_stamp, output ready);
endinterface

interface ffc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/ffc_in_stage.sv =====
// input register stage: captures one frame word per cycle while the word it holds can move on
// depends on ffc_pkg, ffc_if
module ffc_in_stage (
  input  logic              clk,
  input  logic              rst,
  ffc_byte_if.sink          frame,
  input  logic              advance,
  output logic              stage_valid,
  output ffc_pkg::stage_t   stage
);

  assign frame.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (frame.ready) begin
      stage_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      stage.data <= frame.in_byte;
      stage.last <= frame.last_byte;
    end
  end

endmodule

// ===== rtl/ffc_check.sv =====
// per-frame state and checks: position, crc, trailer, header capture, first error
// depends on ffc_pkg
module ffc_check #(
  parameter int FRAME_LEN = 128,
  parameter int MAX_LINKS = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  ffc_pkg::stage_t stage,
  input  logic [7:0]      version,
  output ffc_pkg::res_t   res
);

  localparam logic [7:0] LenBytes = 8'(FRAME_LEN);
  localparam logic [7:0] LenLast  = 8'(FRAME_LEN - 1);
  localparam logic [7:0] CrcEnd   = 8'(FRAME_LEN - 4);
  localparam logic [7:0] LinksMax = 8'(MAX_LINKS);

  logic [7:0]       position_count;
  logic [31:0]      crc_accum, crc_accum_next;
  logic [31:0]      trailer_shift, trailer_shift_next;
  ffc_pkg::status_t first_error, first_error_next, cand;
  logic [7:0]       node_reg, node_reg_next;
  logic [7:0]       flags_reg, flags_reg_next;
  logic [7:0]       count_reg, count_reg_next;
  logic [31:0]      sequence_reg, sequence_reg_next;
  logic [31:0]      epoch_reg, epoch_reg_next;
  ffc_pkg::status_t status;
  logic [7:0]       b, pos;
  logic [31:0]      lane;

  assign b   = stage.data;
  assign pos = position_count;

  // byte shifted into its little-endian lane
  always_comb begin
    case (pos[1:0])
      2'd0:    lane = {24'd0, b};
      2'd1:    lane = {16'd0, b, 8'd0};
      2'd2:    lane = {8'd0, b, 16'd0};
      default: lane = {b, 24'd0};
    endcase
  end

  always_comb begin
    crc_accum_next     = crc_accum;
    trailer_shift_next = trailer_shift;
    node_reg_next      = node_reg;
    flags_reg_next     = flags_reg;
    count_reg_next     = count_reg;
    sequence_reg_next  = sequence_reg;
    epoch_reg_next     = epoch_reg;
    cand               = ffc_pkg::ST_OK;
    if (pos < LenBytes) begin
      if (pos < ffc_pkg::POS_VERSION) begin
        if (b != ffc_pkg::MAGIC[pos[1:0]]) cand = ffc_pkg::ST_MAGIC;
      end else if (pos == ffc_pkg::POS_VERSION) begin
        if (b != version) cand = ffc_pkg::ST_VERSION;
      end else if (pos == ffc_pkg::POS_NODE) begin
        node_reg_next = b;
        if (b == 8'd0) cand = ffc_pkg::ST_NODE;
      end else if (pos == ffc_pkg::POS_FLAGS) begin
        flags_reg_next = b;
      end else if (pos == ffc_pkg::POS_LINKS) begin
        count_reg_next = b;
        if (b > LinksMax) cand = ffc_pkg::ST_LINKS;
      end else if (pos < ffc_pkg::POS_EPOCH) begin
        sequence_reg_next = sequence_reg | lane;
      end else if (pos < ffc_pkg::POS_BODY) begin
        epoch_reg_next = epoch_reg | lane;
      end
      if (pos < CrcEnd) begin
        crc_accum_next = ffc_pkg::crc_byte(crc_accum, b);
      end else begin
        trailer_shift_next = {b, trailer_shift[31:8]};
      end
    end
    first_error_next = (first_error == ffc_pkg::ST_OK) ? cand : first_error;
  end

  always_comb begin
    status = ffc_pkg::ST_OK;
    if (stage.last) begin
      if (pos != LenLast) begin
        status = ffc_pkg::ST_LENGTH;
      end else if (first_error_next != ffc_pkg::ST_OK) begin
        status = first_error_next;
      end else if (~crc_accum_next != trailer_shift_next) begin
        status = ffc_pkg::ST_CRC;
      end
    end
  end

  assign res.data_byte    = b;
  assign res.byte_index   = pos;
  assign res.frame_done   = stage.last;
  assign res.status       = status;
  assign res.node_id      = node_reg_next;
  assign res.header_flags = flags_reg_next;
  assign res.links_used   = count_reg_next;
  assign res.sequence_res = sequence_reg_next;
  assign res.epoch_stamp  = epoch_reg_next;

  always_ff @(posedge clk) begin
    if (rst || (step && stage.last)) begin
      position_count <= 8'd0;
      crc_accum      <= ffc_pkg::CRC_INIT;
      trailer_shift  <= 32'd0;
      first_error    <= ffc_pkg::ST_OK;
      node_reg       <= 8'd0;
      flags_reg      <= 8'd0;
      count_reg      <= 8'd0;
      sequence_reg   <= 32'd0;
      epoch_reg      <= 32'd0;
    end else if (step) begin
      if (position_count != ffc_pkg::POS_MAX) position_count <= 8'(position_count + 8'd1);
      crc_accum      <= crc_accum_next;
      trailer_shift  <= trailer_shift_next;
      first_error    <= first_error_next;
      node_reg       <= node_reg_next;
      flags_reg      <= flags_reg_next;
      count_reg      <= count_reg_next;
      sequence_reg   <= sequence_reg_next;
      epoch_reg      <= epoch_reg_next;
    end
  end

endmodule

// ===== rtl/ffc_out_reg.sv =====
// result register driving the result channel
// depends on ffc_pkg, ffc_if
module ffc_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  ffc_pkg::res_t res,
  output logic          advance,
  ffc_res_if.source     result
);

  ffc_pkg::res_t held;

  assign advance = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      held <= res;
    end
  end

  assign result.data_byte    = held.data_byte;
  assign result.byte_index   = held.byte_index;
  assign result.frame_done   = held.frame_done;
  assign result.status       = held.status;
  assign result.node_id      = held.node_id;
  assign result.header_flags = held.header_flags;
  assign result.links_used   = held.links_used;
  assign result.sequence_res = held.sequence_res;
  assign result.epoch_stamp  = held.epoch_stamp;

endmodule

// ===== rtl/fixed_frame_checker_crc32.sv =====
// top level of the fixed-length frame checker with crc-32 trailer
// depends on ffc_pkg, ffc_if, ffc_in_stage, ffc_check, ffc_out_reg
//
//   channel  | dir | payload                                    | handshake
//   ---------+-----+--------------------------------------------+-------------
//   frame    | in  | in_byte, last_byte                         | valid/ready
//   result   | out | data_byte, byte_index, frame_done, status, | valid/ready
//            |     | node_id, header_flags, links_used,         |
//            |     | sequence_res, epoch_stamp                  |
//   cfg      | in  | data (expected version byte)               | valid/ready
//
// one word per cycle sustained while the result channel takes words; an accepted word passes
//   through the input register, then the result register, before it shows on the result port
// the byte-wide crc update and header checks sit between the two registers
// rst is synchronous: clears both stages, the frame state and sets version to 1
// a stalled result holds the result register; the input register keeps taking a
//   word while the one ahead of it can move, so a bubble never costs throughput
// cfg is always ready and takes effect the next cycle
module fixed_frame_checker_crc32 #(
  parameter int FRAME_LEN = 128,
  parameter int MAX_LINKS = 4
) (
  input  logic      clk,
  input  logic      rst,
  ffc_byte_if.sink  frame,
  ffc_res_if.source result,
  ffc_cfg_if.sink   cfg
);

  logic            stage_valid;
  ffc_pkg::stage_t stage;
  logic            advance;
  ffc_pkg::res_t   res;
  logic [7:0]      expected_version;

  // version register, to be written only between frames: a rule for the user, not enforced by the block
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= ffc_pkg::VERSION_RESET;
    end else if (cfg.valid && cfg.ready) begin
      expected_version <= cfg.data;
    end
  end

  // input register
  ffc_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .frame       (frame),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  // checks and frame state, stepped when the staged word moves on
  ffc_check #(
    .FRAME_LEN (FRAME_LEN),
    .MAX_LINKS (MAX_LINKS)
  ) u_check (
    .clk     (clk),
    .rst     (rst),
    .step    (stage_valid && advance),
    .stage   (stage),
    .version (expected_version),
    .res     (res)
  );

  // result register
  ffc_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (stage_valid),
    .res     (res),
    .advance (advance),
    .result  (result)
  );

endmodule

// ===== rtl/ffc_checker.sv =====
// port-level checks for the frame checker, bound to the top level
// depends on ffc_pkg and the fixed_frame_checker_crc32 ports
module ffc_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] byte_index,
  input logic       frame_done,
  input logic [2:0] status
);

  logic [7:0] exp_index;

  // expected position of the next result word
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_index <= 8'd0;
    end else if (res_valid && res_ready) begin
      if (frame_done) exp_index <= 8'd0;
      else if (byte_index != ffc_pkg::POS_MAX) exp_index <= 8'(byte_index + 8'd1);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_status_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && !frame_done |-> status == ffc_pkg::ST_OK)
    else $error("status set on a word that is not last");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> status <= ffc_pkg::ST_CRC)
    else $error("status code out of range");

  a_index: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> byte_index == exp_index)
    else $error("byte index out of sequence");

endmodule

bind fixed_frame_checker_crc32 ffc_checker u_ffc_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .byte_index (result.byte_index),
  .frame_done (result.frame_done),
  .status     (result.status)
);

// ===== bench/ffc_frame_monitor.sv =====
`timescale 1ns / 1ps
// predicts every result word of the frame checker and compares it with what the dut sends
// depends on ffc_pkg and the ffc_if channel interfaces
module ffc_frame_monitor #(
  parameter int FRAME_LEN = 128,
  parameter int MAX_LINKS = 4
) (
  input  logic clk,
  input  logic rst,
  ffc_byte_if  frame,
  ffc_res_if   result,
  ffc_cfg_if   cfg,
  output int   fail_count,
  output int   pending
);

  logic [7:0]       version_q;
  logic [7:0]       pos_q;
  logic [31:0]      crc_q;
  logic [31:0]      trailer_q;
  ffc_pkg::status_t err_q;
  logic [7:0]       node_q;
  logic [7:0]       flags_q;
  logic [7:0]       links_q;
  logic [31:0]      seq_q;
  logic [31:0]      epoch_q;
  ffc_pkg::res_t    awaited_words[$];

  // bit-serial form of the reflected crc-32
  function automatic logic [31:0] crc_shift_in(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[31:1]} ^ (fb ? ffc_pkg::CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic string describe_word(input ffc_pkg::res_t r);
    return $sformatf({"byte %02h idx %0d done %0b status %0d node %02h flags %02h ",
                      "links %02h seq %08h epoch %08h"},
                     r.data_byte, r.byte_index, r.frame_done, r.status, r.node_id,
                     r.header_flags, r.links_used, r.sequence_res, r.epoch_stamp);
  endfunction

  task automatic restart_frame();
    pos_q     = '0;
    crc_q     = ffc_pkg::CRC_INIT;
    trailer_q = '0;
    err_q     = ffc_pkg::ST_OK;
    node_q    = '0;
    flags_q   = '0;
    links_q   = '0;
    seq_q     = '0;
    epoch_q   = '0;
  endtask

  task automatic note_fail(input ffc_pkg::status_t s);
    if (err_q == ffc_pkg::ST_OK) err_q = s;
  endtask

  // one accepted frame word in, the result word it should produce out
  task automatic advance_frame(input logic [7:0] b, input logic l, output ffc_pkg::res_t w);
    logic [7:0]       p;
    ffc_pkg::status_t st;
    p  = pos_q;
    st = ffc_pkg::ST_OK;
    if (p < FRAME_LEN) begin
      if (p < ffc_pkg::POS_VERSION) begin
        if (b != ffc_pkg::MAGIC[p[1:0]]) note_fail(ffc_pkg::ST_MAGIC);
      end else if (p == ffc_pkg::POS_VERSION) begin
        if (b != version_q) note_fail(ffc_pkg::ST_VERSION);
      end else if (p == ffc_pkg::POS_NODE) begin
        node_q = b;
        if (b == 8'd0) note_fail(ffc_pkg::ST_NODE);
      end else if (p == ffc_pkg::POS_FLAGS) begin
        flags_q = b;
      end else if (p == ffc_pkg::POS_LINKS) begin
        links_q = b;
        if (b > MAX_LINKS) note_fail(ffc_pkg::ST_LINKS);
      end else if (p < ffc_pkg::POS_EPOCH) begin
        seq_q |= 32'(b) << (8 * (p - ffc_pkg::POS_SEQ));
      end else if (p < ffc_pkg::POS_BODY) begin
        epoch_q |= 32'(b) << (8 * (p - ffc_pkg::POS_EPOCH));
      end
      // crc over all but the last four bytes, which shift in as the trailer
      if (p < FRAME_LEN - 4) begin
        crc_q = crc_shift_in(crc_q, b);
      end else begin
        trailer_q = {b, trailer_q[31:8]};
      end
    end
    if (l) begin
      if (p != FRAME_LEN - 1) st = ffc_pkg::ST_LENGTH;
      else if (err_q != ffc_pkg::ST_OK) st = err_q;
      else if (~crc_q != trailer_q) st = ffc_pkg::ST_CRC;
    end
    w.data_byte    = b;
    w.byte_index   = p;
    w.frame_done   = l;
    w.status       = st;
    w.node_id      = node_q;
    w.header_flags = flags_q;
    w.links_used   = links_q;
    w.sequence_res = seq_q;
    w.epoch_stamp  = epoch_q;
    if (l) restart_frame();
    else if (p != ffc_pkg::POS_MAX) pos_q = p + 8'd1;
  endtask

  task automatic log_fail(input string why, input bit have_exp, input ffc_pkg::res_t e,
                          input ffc_pkg::res_t g);
    if (fail_count < 10) begin
      $display("%0t: %s", $time, why);
      if (have_exp) $display("  expected %s", describe_word(e));
      $display("  actual   %s", describe_word(g));
    end
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    ffc_pkg::res_t w;
    ffc_pkg::res_t got;
    if (rst) begin
      restart_frame();
      version_q  = ffc_pkg::VERSION_RESET;
      fail_count = 0;
      awaited_words.delete();
    end else begin
      if (frame.valid && frame.ready) begin
        advance_frame(frame.in_byte, frame.last_byte, w);
        awaited_words.push_back(w);
      end
      // new version counts from the next word on
      if (cfg.valid && cfg.ready) version_q = cfg.data;
      if (result.valid && result.ready) begin
        got.data_byte    = result.data_byte;
        got.byte_index   = result.byte_index;
        got.frame_done   = result.frame_done;
        got.status       = result.status;
        got.node_id      = result.node_id;
        got.header_flags = result.header_flags;
        got.links_used   = result.links_used;
        got.sequence_res = result.sequence_res;
        got.epoch_stamp  = result.epoch_stamp;
        if (awaited_words.size() == 0) begin
          log_fail("result word with none awaited", 1'b0, got, got);
        end else begin
          w = awaited_words.pop_front();
          if (got.data_byte !== w.data_byte || got.byte_index !== w.byte_index ||
              got.frame_done !== w.frame_done || got.status !== w.status ||
              got.node_id !== w.node_id || got.header_flags !== w.header_flags ||
              got.links_used !== w.links_used || got.sequence_res !== w.sequence_res ||
              got.epoch_stamp !== w.epoch_stamp) begin
            log_fail("result word mismatch", 1'b1, w, got);
          end
        end
      end
    end
    pending = awaited_words.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// bench top for fixed_frame_checker_crc32: clock, reset, frame and version stimulus, verdict
// depends on ffc_pkg, ffc_if, ffc_frame_monitor and the dut
module tb;

  localparam int FRAME_LEN       = 128;
  localparam int MAX_LINKS       = 4;
  localparam int LIMIT_CYCLES    = 400000;
  localparam int ITEMS_PER_PHASE = 340;
  localparam int N_PHASES        = 5;

  // what gets broken in a generated frame
  typedef enum int {
    F_NONE, F_MAGIC, F_VERSION, F_NODE, F_LINKS, F_CRC, F_SEVERAL
  } fault_kind_t;
  localparam int N_FAULTS = int'(F_SEVERAL) + 1;

  // frame shapes: proper length, cut short, overrun, plain noise
  typedef enum int {
    K_FULL, K_SHORT, K_LONG, K_NOISE
  } frame_kind_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  int         fail_count;
  int         pending;
  int         cycles;
  int         sent_items;
  int         idle_pct;
  int         stall_pct;
  int         pause_at;
  int         fault_seq;
  logic [7:0] cur_version;
  logic [7:0] frame_buf[$];

  ffc_byte_if frame_ch();
  ffc_res_if  result_ch();
  ffc_cfg_if  cfg_ch();

  fixed_frame_checker_crc32 #(
    .FRAME_LEN(FRAME_LEN),
    .MAX_LINKS(MAX_LINKS)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .frame (frame_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  // watches all three channels, predicts each result word and counts failures
  ffc_frame_monitor #(
    .FRAME_LEN(FRAME_LEN),
    .MAX_LINKS(MAX_LINKS)
  ) u_monitor (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame_ch),
    .result    (result_ch),
    .cfg       (cfg_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  // receiver back-pressure, redrawn every cycle at the falling edge
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // hard stop in case the dut hangs
  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb failed");
    $finish;
  end

  // one frame word: optional idle gap, then hold it until the dut takes it
  task automatic send_word(input logic [7:0] b, input logic l);
    if ($urandom_range(99) < idle_pct) begin
      frame_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    frame_ch.valid     <= 1'b1;
    frame_ch.in_byte   <= b;
    frame_ch.last_byte <= l;
    do @(posedge clk); while (!frame_ch.ready);
    @(negedge clk);
    sent_items++;
  endtask

  // stop sending and wait until every awaited result word has come back
  task automatic wait_drain();
    frame_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_version(input logic [7:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cur_version = v;
  endtask

  // sends frame_buf with the last mark on its final word; may pause once for a full drain
  task automatic send_buf();
    for (int i = 0; i < frame_buf.size(); i++) begin
      if (i == pause_at) begin
        wait_drain();
        pause_at = -1;
      end
      send_word(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  task automatic send_frame(input frame_kind_t kind);
    fault_kind_t f;
    logic [31:0] crc;
    int          n;
    frame_buf.delete();
    if (kind == K_NOISE) begin
      n = $urandom_range(1, 24);
      repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      // full frames walk through every fault in turn, the others pick one at random
      if (kind == K_FULL) begin
        f = fault_kind_t'(fault_seq % N_FAULTS);
        fault_seq++;
      end else begin
        f = fault_kind_t'($urandom_range(0, N_FAULTS - 1));
      end
      // well-formed header: magic, version, node, flags, links, sequence, epoch
      for (int i = 0; i < 4; i++) frame_buf.push_back(ffc_pkg::MAGIC[i]);
      frame_buf.push_back(cur_version);
      frame_buf.push_back(8'($urandom_range(1, 255)));
      frame_buf.push_back(8'($urandom_range(0, 255)));
      frame_buf.push_back(8'($urandom_range(0, MAX_LINKS)));
      while (frame_buf.size() < FRAME_LEN - 4) frame_buf.push_back(8'($urandom_range(0, 255)));
      case (f)
        F_MAGIC:   frame_buf[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
        F_VERSION: frame_buf[ffc_pkg::POS_VERSION] ^= 8'($urandom_range(1, 255));
        F_NODE:    frame_buf[ffc_pkg::POS_NODE] = 8'd0;
        F_LINKS:   frame_buf[ffc_pkg::POS_LINKS] = 8'($urandom_range(MAX_LINKS + 1, 255));
        F_SEVERAL: begin
          // one or more faults at once, the earliest must win
          frame_buf[ffc_pkg::POS_NODE] = 8'd0;
          if ($urandom_range(1)) begin
            frame_buf[ffc_pkg::POS_VERSION] ^= 8'($urandom_range(1, 255));
          end
          if ($urandom_range(1)) begin
            frame_buf[ffc_pkg::POS_LINKS] = 8'($urandom_range(MAX_LINKS + 1, 255));
          end
          if ($urandom_range(3) == 0) frame_buf[$urandom_range(0, 3)] ^= 8'h20;
        end
        default: ;
      endcase
      // little-endian trailer over everything sent so far
      crc = ffc_pkg::CRC_INIT;
      foreach (frame_buf[i]) crc = ffc_pkg::crc_byte(crc, frame_buf[i]);
      crc = ~crc;
      for (int i = 0; i < 4; i++) frame_buf.push_back(crc[8*i +: 8]);
      // corrupt one bit past the checked header so only the crc can catch it
      if (f == F_CRC) begin
        frame_buf[$urandom_range(ffc_pkg::POS_SEQ, FRAME_LEN - 1)] ^=
          8'(1 << $urandom_range(0, 7));
      end
      if (kind == K_SHORT) begin
        n = $urandom_range(1, FRAME_LEN - 1);
        while (frame_buf.size() > n) void'(frame_buf.pop_back());
      end else if (kind == K_LONG) begin
        // up to well past 256 words so the position saturates
        n = $urandom_range(1, 150);
        repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
      end
    end
    send_buf();
  endtask

  initial begin
    int          phase_start;
    int          r;
    logic [7:0]  v;
    frame_kind_t kind;

    frame_ch.valid     = 1'b0;
    frame_ch.in_byte   = 8'd0;
    frame_ch.last_byte = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = 8'd0;
    result_ch.ready    = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    pause_at    = -1;
    fault_seq   = 0;
    sent_items  = 0;
    cur_version = ffc_pkg::VERSION_RESET;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: one-word frames at both byte extremes
    frame_buf = '{8'h00};
    send_buf();
    frame_buf = '{8'hFF};
    send_buf();
    // header only, cut after the epoch: length error with every field captured
    frame_buf = '{ffc_pkg::MAGIC[0], ffc_pkg::MAGIC[1], ffc_pkg::MAGIC[2], ffc_pkg::MAGIC[3],
                  ffc_pkg::VERSION_RESET, 8'hFF, 8'hFF, 8'h00,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h80};
    send_buf();
    // bad magic and bad version, both cut short so length still wins
    frame_buf = '{ffc_pkg::MAGIC[0], 8'h00};
    send_buf();
    frame_buf = '{ffc_pkg::MAGIC[0], ffc_pkg::MAGIC[1], ffc_pkg::MAGIC[2], ffc_pkg::MAGIC[3],
                  8'h00};
    send_buf();

    // random phases, each setting its version and idling pattern
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drain();
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      case (p)
        0: v = 8'h00;
        1: v = 8'hFF;
        3: v = ffc_pkg::VERSION_RESET;
        default: v = 8'($urandom_range(0, 255));
      endcase
      write_version(v);
      phase_start = sent_items;
      // first frame of a phase stops once midway until the dut has drained
      pause_at = $urandom_range(1, FRAME_LEN - 1);
      send_frame(K_FULL);
      while (sent_items - phase_start < ITEMS_PER_PHASE) begin
        r    = $urandom_range(99);
        kind = r < 45 ? K_FULL : r < 70 ? K_SHORT : r < 82 ? K_LONG : K_NOISE;
        send_frame(kind);
      end
    end

    wait_drain();
    // keep the clock running to catch any stray result word
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
